[design/assert_macros.svh]
// Assertion helpers for the checker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every edge, except while reset is held
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/alrgb_pkg.sv]
package alrgb_pkg;

    localparam int SAMPLE_BITS    = 10;
    localparam int LIMIT_OUT_BITS = 10;
    localparam int SCALE_BITS     = 16;
    localparam int Q_BITS         = 16;
    localparam int NUM_BITS       = SAMPLE_BITS + SCALE_BITS;
    localparam int DIV_CNT_BITS   = $clog2(NUM_BITS + 1);

    localparam logic [SCALE_BITS-1:0]  SCALE_MUL     = 16'd33279;
    localparam logic [Q_BITS-1:0]      GUARD_BAND    = 16'd512;
    localparam logic [Q_BITS-1:0]      GREEN_START   = 16'h2aaa;
    localparam logic [Q_BITS-1:0]      BLUE_START    = 16'h5555;
    localparam logic [SAMPLE_BITS-1:0] LOW_RESET     = SAMPLE_BITS'(511);
    localparam logic [SAMPLE_BITS-1:0] HIGH_RESET    = SAMPLE_BITS'(512);
    localparam logic [7:0]             HOLDOFF_RESET = 8'd64;

    typedef struct packed {
        logic                   start;
        logic [NUM_BITS-1:0]    numer;
        logic [SAMPLE_BITS-1:0] denom;
    } t_div_req;

    function automatic logic [LIMIT_OUT_BITS-1:0] fit_limit(input logic [SAMPLE_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[LIMIT_OUT_BITS-1:0];
    endfunction

endpackage

[design/alrgb_div.sv]
module alrgb_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  alrgb_pkg::t_div_req                i_req,
    output logic                               o_done,
    output logic [alrgb_pkg::Q_BITS-1:0]       o_quotient
);
    import alrgb_pkg::*;

    logic [NUM_BITS-1:0]     r_nq;
    logic [SAMPLE_BITS-1:0]  r_rem;
    logic [SAMPLE_BITS-1:0]  r_denom;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_busy;
    logic                    r_done;

    logic [SAMPLE_BITS:0]    rem_sh;
    logic [SAMPLE_BITS:0]    diff;
    logic                    ge;

    always_comb begin
        rem_sh = {r_rem, r_nq[NUM_BITS-1]};
        diff   = rem_sh - {1'b0, r_denom};
        ge     = rem_sh >= {1'b0, r_denom};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_cnt   <= DIV_CNT_BITS'(NUM_BITS);
            r_nq    <= i_req.numer;
            r_rem   <= '0;
            r_denom <= i_req.denom;
        end else if (r_busy) begin
            r_nq  <= {r_nq[NUM_BITS-2:0], ge};
            r_rem <= ge ? diff[SAMPLE_BITS-1:0] : rem_sh[SAMPLE_BITS-1:0];
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_BITS'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_nq[Q_BITS-1:0];

endmodule

[design/autorange_light_to_rgb_core.sv]
// Light sensor to RGB PWM compare values with self-calibrating range.
// Input channel i_valid/o_ready carries one ADC sample per transfer; the
// running limits and the save holdoff count update at that transfer.
// Output channel o_valid/i_ready carries the inverted red, green and blue
// compare values, the save request and the limits after that sample.
// Configuration channel i_cfg_valid/o_cfg_ready writes the save holdoff;
// it is always ready.
// A sample passes the multiply, divider load, divide-until-done and ramp
// states in turn; the restoring divider yields one quotient bit per cycle
// over SAMPLE_BITS + 16 bits. A new sample is taken only once the last
// result has left the ramp stage into the output register.
// Reset: limits go to 511 and 512, holdoff count to 0, holdoff register
// to 64, output channel empty; the block is ready in the cycle after reset.
// Stall: a result held by the receiver stays in the output register; the
// next sample is accepted and computed meanwhile, and waits at the ramp
// stage until the output register frees.
module autorange_light_to_rgb_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [alrgb_pkg::SAMPLE_BITS-1:0]      i_sample,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [7:0]                             o_red_compare,
    output logic [7:0]                             o_green_compare,
    output logic [7:0]                             o_blue_compare,
    output logic                                   o_save_request,
    output logic [alrgb_pkg::LIMIT_OUT_BITS-1:0]   o_low_limit_out,
    output logic [alrgb_pkg::LIMIT_OUT_BITS-1:0]   o_high_limit_out,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [7:0]                             i_cfg_data
);
    import alrgb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_POST  = 3'd4;

    logic [2:0]             r_state;
    logic [7:0]             r_save_holdoff;
    logic [SAMPLE_BITS-1:0] r_low;
    logic [SAMPLE_BITS-1:0] r_high;
    logic [7:0]             r_hold;
    logic [SAMPLE_BITS-1:0] r_level;
    logic [SAMPLE_BITS-1:0] r_span;
    logic                   r_save;
    logic [NUM_BITS-1:0]    r_prod;
    logic                   r_out_valid;
    logic [7:0]             r_red;
    logic [7:0]             r_green;
    logic [7:0]             r_blue;
    logic                   r_save_out;
    logic [SAMPLE_BITS-1:0] r_low_out;
    logic [SAMPLE_BITS-1:0] r_high_out;

    logic [SAMPLE_BITS-1:0] n_low;
    logic [SAMPLE_BITS-1:0] n_high;
    logic [7:0]             n_hold;
    logic                   n_save;
    logic [SAMPLE_BITS-1:0] n_span;
    logic                   widen;

    logic                   in_xfer;
    logic                   out_free;
    t_div_req               div_req;
    logic                   div_done;
    logic [Q_BITS-1:0]      div_q;

    logic [Q_BITS-1:0]      lvl;
    logic [Q_BITS+1:0]      g_prod;
    logic [Q_BITS+1:0]      b_prod;
    logic [7:0]             red_v;
    logic [7:0]             green_v;
    logic [7:0]             blue_v;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;

    always_comb begin
        n_low  = (i_sample < r_low) ? i_sample : r_low;
        n_high = (i_sample > r_high) ? i_sample : r_high;
        widen  = (i_sample < r_low) || (i_sample > r_high);
        n_hold = widen ? r_save_holdoff : r_hold;
        if (n_hold > 8'd1) begin
            n_hold = n_hold - 8'd1;
        end
        n_save = 1'b0;
        if (n_hold == 8'd1) begin
            n_save = 1'b1;
            n_hold = 8'd0;
        end
        n_span = (n_high > n_low) ? (n_high - n_low) : SAMPLE_BITS'(1);
    end

    assign div_req.start = (r_state == S_START);
    assign div_req.numer = r_prod;
    assign div_req.denom = r_span;

    alrgb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        lvl     = (div_q < GUARD_BAND) ? '0 : (div_q - GUARD_BAND);
        red_v   = lvl[14:7];
        g_prod  = 18'(lvl - GREEN_START) * 18'd3;
        b_prod  = 18'(lvl - BLUE_START) * 18'd3;
        green_v = (lvl < GREEN_START) ? 8'd0 : g_prod[15:8];
        blue_v  = (lvl < BLUE_START) ? 8'd0 : b_prod[14:7];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_save_holdoff <= HOLDOFF_RESET;
            r_low          <= LOW_RESET;
            r_high         <= HIGH_RESET;
            r_hold         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_save_holdoff <= i_cfg_data;
            end
            if (r_out_valid && i_ready && (r_state != S_POST)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_low   <= n_low;
                        r_high  <= n_high;
                        r_hold  <= n_hold;
                        r_save  <= n_save;
                        r_span  <= n_span;
                        r_level <= i_sample - n_low;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= NUM_BITS'(r_level) * NUM_BITS'(SCALE_MUL);
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_red       <= ~red_v;
                        r_green     <= ~green_v;
                        r_blue      <= ~blue_v;
                        r_save_out  <= r_save;
                        r_low_out   <= r_low;
                        r_high_out  <= r_high;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_red_compare    = r_red;
    assign o_green_compare  = r_green;
    assign o_blue_compare   = r_blue;
    assign o_save_request   = r_save_out;
    assign o_low_limit_out  = fit_limit(r_low_out);
    assign o_high_limit_out = fit_limit(r_high_out);

endmodule

[design/alrgb_checker.sv]
`include "assert_macros.svh"

module alrgb_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_ready,
    input logic                                   o_valid,
    input logic                                   i_ready,
    input logic [alrgb_pkg::LIMIT_OUT_BITS-1:0]   o_low_limit_out,
    input logic [alrgb_pkg::LIMIT_OUT_BITS-1:0]   o_high_limit_out
);
    import alrgb_pkg::*;

    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "result dropped before transfer")
    `ASSERT_CLK_RST(a_busy_after_in, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready, "input taken again while busy")
    `ASSERT_CLK_RST(a_limits_order, i_clk, i_rst_n, o_valid |-> o_low_limit_out <= o_high_limit_out, "limits out of order")
    `ASSERT_CLK(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result shown after reset")

endmodule

bind autorange_light_to_rgb_core alrgb_checker u_alrgb_checker (.*);
